/* sv/iss_pkg.sv */
// ---------------------------------------------------------------------------
// iss_pkg: shared types for the indexed sequence store
// Opcodes, status codes, controller states and the per-cell control word.
// ---------------------------------------------------------------------------
package iss_pkg;

	typedef enum logic [2:0] {
		OP_CLEAR  = 3'd0,
		OP_INSERT = 3'd1,
		OP_REMOVE = 3'd2,
		OP_READ   = 3'd3,
		OP_PURGE  = 3'd4,
		OP_COUNT  = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_RANGE = 2'd2,
		STAT_FULL  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SWEEP,
		ST_RESP
	} state_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_SWEEP
	} cell_mode_t;

	// Broadcast to every cell in the chain
	typedef struct packed {
		cell_mode_t mode;
		logic       keep;   // sweep: head entry is written back at the tail position
	} cell_ctrl_t;

endpackage

/* sv/iss_cell.sv */
// ---------------------------------------------------------------------------
// iss_cell: one storage cell of the sequence chain
// Holds one entry; shifts from its left neighbour on insert, from its right
// neighbour on a sweep step, or takes a broadcast value at its own position.
// ---------------------------------------------------------------------------
module iss_cell #(
	parameter int POS = 0,
	parameter int PW  = 6,
	parameter int EW  = 16
) (
	input  logic                clk,
	input  iss_pkg::cell_ctrl_t ctrl,
	input  logic [PW-1:0]       sel_pos,
	input  logic [EW-1:0]       ins_val,
	input  logic [EW-1:0]       head,
	input  logic [EW-1:0]       left,
	input  logic [EW-1:0]       right,
	output logic [EW-1:0]       entry
);

	localparam logic [PW-1:0] MyPos = PW'(POS);

	logic [EW-1:0] entry_q;

	always_ff @(posedge clk) begin
		case (ctrl.mode)
			iss_pkg::CELL_INSERT: begin
				if (sel_pos == MyPos) begin
					entry_q <= ins_val;
				end else if (MyPos > sel_pos) begin
					entry_q <= left;
				end
			end
			iss_pkg::CELL_SWEEP: begin
				// shift towards the head; the kept head entry lands at the tail slot
				if (ctrl.keep && (sel_pos == MyPos)) begin
					entry_q <= head;
				end else begin
					entry_q <= right;
				end
			end
			default: begin
			end
		endcase
	end

	assign entry = entry_q;

endmodule

/* sv/iss_ctrl.sv */
// ---------------------------------------------------------------------------
// iss_ctrl: request sequencer for the indexed sequence store
// Checks each request, drives the cell chain through an insert or a sweep
// and holds the result until it is transferred.
// ---------------------------------------------------------------------------
module iss_ctrl #(
	parameter int CAPACITY      = 64,
	parameter int ELEMENT_WIDTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  logic [2:0]                        opcode,
	input  logic [15:0]                       value,
	input  logic [6:0]                        index,
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output logic [1:0]                        status,
	output logic [15:0]                       data,
	output logic [6:0]                        match_count,
	output logic [6:0]                        length,
	input  logic [ELEMENT_WIDTH-1:0]          head,
	output iss_pkg::cell_ctrl_t               cell_ctrl,
	output logic [$clog2(CAPACITY)-1:0]       sel_pos,
	output logic [ELEMENT_WIDTH-1:0]          ins_val
);

	localparam int PW = $clog2(CAPACITY);
	localparam int LW = $clog2(CAPACITY + 1);
	localparam int CW = (LW > 7) ? LW : 7;

	iss_pkg::state_t           state_q, state_d;
	iss_pkg::op_t              op_q;
	iss_pkg::status_t          status_q;
	logic [ELEMENT_WIDTH-1:0]  val_q;
	logic [6:0]                idx_q;
	logic [LW-1:0]             len_q;
	logic [LW-1:0]             w_q;
	logic [LW-1:0]             match_q;
	logic [PW-1:0]             k_q;
	logic [PW-1:0]             wpos_q;
	logic [15:0]               data_q;

	logic empty, full, ins_range, acc_range, hit, match, last, keep;

	assign empty     = (len_q == '0);
	assign full      = (len_q >= LW'(CAPACITY));
	assign ins_range = (CW'(idx_q) > CW'(len_q));
	assign acc_range = (CW'(idx_q) >= CW'(len_q));
	assign hit       = (CW'(k_q) == CW'(idx_q));
	assign match     = (head == val_q);
	assign last      = ((LW'(k_q) + LW'(1)) == len_q);

	always_comb begin
		case (op_q)
			iss_pkg::OP_REMOVE: keep = !hit;
			iss_pkg::OP_PURGE:  keep = !match;
			default:            keep = 1'b1;
		endcase
	end

	always_comb begin
		state_d        = state_q;
		cell_ctrl.mode = iss_pkg::CELL_HOLD;
		cell_ctrl.keep = keep;
		sel_pos        = wpos_q;
		case (state_q)
			iss_pkg::ST_IDLE: begin
				if (req_valid) begin
					state_d = iss_pkg::ST_EXEC;
				end
			end
			iss_pkg::ST_EXEC: begin
				case (op_q)
					iss_pkg::OP_INSERT: begin
						state_d = iss_pkg::ST_RESP;
						if (!full && (empty || !ins_range)) begin
							cell_ctrl.mode = iss_pkg::CELL_INSERT;
							sel_pos        = empty ? '0 : PW'(idx_q);
						end
					end
					iss_pkg::OP_REMOVE, iss_pkg::OP_READ: begin
						state_d = (empty || acc_range) ? iss_pkg::ST_RESP : iss_pkg::ST_SWEEP;
					end
					iss_pkg::OP_PURGE, iss_pkg::OP_COUNT: begin
						state_d = empty ? iss_pkg::ST_RESP : iss_pkg::ST_SWEEP;
					end
					default: begin
						state_d = iss_pkg::ST_RESP;
					end
				endcase
			end
			iss_pkg::ST_SWEEP: begin
				cell_ctrl.mode = iss_pkg::CELL_SWEEP;
				if (last) begin
					state_d = iss_pkg::ST_RESP;
				end
			end
			iss_pkg::ST_RESP: begin
				if (!rsp_stall) begin
					state_d = iss_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = iss_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= iss_pkg::ST_IDLE;
			len_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == iss_pkg::ST_EXEC) begin
				if (op_q == iss_pkg::OP_CLEAR) begin
					len_q <= '0;
				end else if (cell_ctrl.mode == iss_pkg::CELL_INSERT) begin
					len_q <= len_q + LW'(1);
				end
			end else if ((state_q == iss_pkg::ST_SWEEP) && last) begin
				len_q <= w_q + LW'(keep);
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			iss_pkg::ST_IDLE: begin
				if (req_valid) begin
					op_q  <= iss_pkg::op_t'(opcode);
					val_q <= ELEMENT_WIDTH'(value);
					idx_q <= index;
				end
			end
			iss_pkg::ST_EXEC: begin
				data_q  <= '0;
				match_q <= '0;
				k_q     <= '0;
				w_q     <= '0;
				wpos_q  <= PW'(len_q - LW'(1));
				case (op_q)
					iss_pkg::OP_INSERT: begin
						if (full) begin
							status_q <= iss_pkg::STAT_FULL;
						end else if (!empty && ins_range) begin
							status_q <= iss_pkg::STAT_RANGE;
						end else begin
							status_q <= iss_pkg::STAT_OK;
						end
					end
					iss_pkg::OP_REMOVE, iss_pkg::OP_READ: begin
						if (empty) begin
							status_q <= iss_pkg::STAT_EMPTY;
						end else if (acc_range) begin
							status_q <= iss_pkg::STAT_RANGE;
						end else begin
							status_q <= iss_pkg::STAT_OK;
						end
					end
					default: begin
						status_q <= iss_pkg::STAT_OK;
					end
				endcase
			end
			iss_pkg::ST_SWEEP: begin
				k_q <= k_q + PW'(1);
				// tail slot = len - k - 1 + kept; stays put when the head is kept
				if (keep) begin
					w_q <= w_q + LW'(1);
				end else begin
					wpos_q <= wpos_q - PW'(1);
				end
				if (hit && ((op_q == iss_pkg::OP_READ) || (op_q == iss_pkg::OP_REMOVE))) begin
					data_q <= 16'(head);
				end
				if (match && ((op_q == iss_pkg::OP_PURGE) || (op_q == iss_pkg::OP_COUNT))) begin
					match_q <= match_q + LW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	assign req_stall   = (state_q != iss_pkg::ST_IDLE);
	assign rsp_valid   = (state_q == iss_pkg::ST_RESP);
	assign status      = status_q;
	assign data        = data_q;
	assign match_count = 7'(match_q);
	assign length      = 7'(len_q);
	assign ins_val     = val_q;

endmodule

/* sv/indexed_sequence_store_unit.sv */
// ---------------------------------------------------------------------------
// indexed_sequence_store_unit: positional list of up to CAPACITY values
// Request channel (req_valid/req_stall): opcode, value, index. Response
// channel (rsp_valid/rsp_stall): status, data, match_count, length.
// One response per request, in order. A transfer happens on a rising edge
// with valid high and stall low.
// Read, remove, purge and count sweep the chain, one chain step per entry
// (length as it stood before the request); clear, insert, no-op and any
// rejected request go straight to the response.
// The block holds one request at a time: req_stall is high from the request
// transfer until the response has been transferred, so a new request can be
// taken in the cycle after the response transfer.
// Reset (arst_n low) empties the list; entry contents are not cleared and
// there is no clearing pass. While rsp_stall is high the response and the
// list state are simply held.
// ---------------------------------------------------------------------------
module indexed_sequence_store_unit #(
	parameter int CAPACITY      = 64,
	parameter int ELEMENT_WIDTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [2:0]  opcode,
	input  logic [15:0] value,
	input  logic [6:0]  index,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [1:0]  status,
	output logic [15:0] data,
	output logic [6:0]  match_count,
	output logic [6:0]  length
);

	localparam int PW = $clog2(CAPACITY);

	// Broadcast control from the sequencer to every cell
	iss_pkg::cell_ctrl_t      cell_ctrl;
	logic [PW-1:0]            sel_pos;
	logic [ELEMENT_WIDTH-1:0] ins_val;

	// Entry held in each cell; cell 0 is the list head
	logic [ELEMENT_WIDTH-1:0] entry_w [CAPACITY];

	iss_ctrl #(
		.CAPACITY      (CAPACITY),
		.ELEMENT_WIDTH (ELEMENT_WIDTH)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.opcode      (opcode),
		.value       (value),
		.index       (index),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.status      (status),
		.data        (data),
		.match_count (match_count),
		.length      (length),
		.head        (entry_w[0]),
		.cell_ctrl   (cell_ctrl),
		.sel_pos     (sel_pos),
		.ins_val     (ins_val)
	);

	// Chain of cells. Insert: cells past the insert position take their left
	// neighbour. Sweep: every cell takes its right neighbour, so the head walks
	// out of cell 0 one entry per cycle; a kept head is written back at the
	// current tail slot, a dropped one (removed or purged) is simply lost.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [ELEMENT_WIDTH-1:0] left_w;
		logic [ELEMENT_WIDTH-1:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = entry_w[i];
		end else begin : g_mid_l
			assign left_w = entry_w[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_w = entry_w[i];
		end else begin : g_mid_r
			assign right_w = entry_w[i+1];
		end

		iss_cell #(
			.POS (i),
			.PW  (PW),
			.EW  (ELEMENT_WIDTH)
		) u_cell (
			.clk     (clk),
			.ctrl    (cell_ctrl),
			.sel_pos (sel_pos),
			.ins_val (ins_val),
			.head    (entry_w[0]),
			.left    (left_w),
			.right   (right_w),
			.entry   (entry_w[i])
		);
	end

endmodule
